@@ hw/rtl/apfp_pkg.sv @@
// Shared word types, field codes and field length table for the AVL packet field parser.
package apfp_pkg;

    localparam int unsigned CODE_W  = 5;
    localparam int unsigned INDEX_W = 4;

    // Field codes in packet order; PHASE_IDLE marks no packet in progress
    localparam logic [CODE_W-1:0] F_PREAMBLE    = 5'd0;
    localparam logic [CODE_W-1:0] F_LENGTH      = 5'd1;
    localparam logic [CODE_W-1:0] F_CODEC       = 5'd2;
    localparam logic [CODE_W-1:0] F_REC_COUNT1  = 5'd3;
    localparam logic [CODE_W-1:0] F_TIMESTAMP   = 5'd4;
    localparam logic [CODE_W-1:0] F_PRIORITY    = 5'd5;
    localparam logic [CODE_W-1:0] F_LONGITUDE   = 5'd6;
    localparam logic [CODE_W-1:0] F_LATITUDE    = 5'd7;
    localparam logic [CODE_W-1:0] F_ALTITUDE    = 5'd8;
    localparam logic [CODE_W-1:0] F_ANGLE       = 5'd9;
    localparam logic [CODE_W-1:0] F_SATELLITES  = 5'd10;
    localparam logic [CODE_W-1:0] F_SPEED       = 5'd11;
    localparam logic [CODE_W-1:0] F_EVENT_IO_ID = 5'd12;
    localparam logic [CODE_W-1:0] F_TOTAL_IO    = 5'd13;
    localparam logic [CODE_W-1:0] F_IO1_COUNT   = 5'd14;
    localparam logic [CODE_W-1:0] F_IO1_ENTRY   = 5'd15;
    localparam logic [CODE_W-1:0] F_IO2_COUNT   = 5'd16;
    localparam logic [CODE_W-1:0] F_IO2_ENTRY   = 5'd17;
    localparam logic [CODE_W-1:0] F_IO4_COUNT   = 5'd18;
    localparam logic [CODE_W-1:0] F_IO4_ENTRY   = 5'd19;
    localparam logic [CODE_W-1:0] F_IO8_COUNT   = 5'd20;
    localparam logic [CODE_W-1:0] F_IO8_ENTRY   = 5'd21;
    localparam logic [CODE_W-1:0] F_REC_COUNT2  = 5'd22;
    localparam logic [CODE_W-1:0] F_CRC         = 5'd23;
    localparam logic [CODE_W-1:0] PHASE_IDLE    = 5'd24;

    // One raw byte of the packet
    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_start;
    } in_word_t;

    // One completed field
    typedef struct packed {
        logic [CODE_W-1:0] field_code;
        logic [7:0]        io_id;
        logic [63:0]       field_value;
        logic              packet_end;
    } out_word_t;

    // Bytes per field, id byte included for IO entries
    function automatic logic [INDEX_W-1:0] field_len(input logic [CODE_W-1:0] code);
        logic [INDEX_W-1:0] len;
        begin
            unique case (code)
                F_PREAMBLE, F_LENGTH, F_LONGITUDE, F_LATITUDE,
                F_CRC:                                  len = 4'd4;
                F_TIMESTAMP:                            len = 4'd8;
                F_ALTITUDE, F_ANGLE, F_SPEED,
                F_IO1_ENTRY:                            len = 4'd2;
                F_IO2_ENTRY:                            len = 4'd3;
                F_IO4_ENTRY:                            len = 4'd5;
                F_IO8_ENTRY:                            len = 4'd9;
                F_CODEC, F_REC_COUNT1, F_PRIORITY, F_SATELLITES,
                F_EVENT_IO_ID, F_TOTAL_IO, F_IO1_COUNT, F_IO2_COUNT,
                F_IO4_COUNT, F_IO8_COUNT, F_REC_COUNT2: len = 4'd1;
                default:                                len = 4'd0;
            endcase
            return len;
        end
    endfunction

endpackage

@@ hw/rtl/apfp_front.sv @@
// Front end: accepts raw byte words and holds them in a short queue for the parser.
module apfp_front #(
    parameter int unsigned DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  apfp_pkg::in_word_t byte_word,
    output logic              q_valid,
    output apfp_pkg::in_word_t q_word,
    input  logic              q_pop
);
    import apfp_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    in_word_t           slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               push;

    // Stall only on a full queue
    assign byte_stall = (count_reg == FULL_CNT);
    assign push       = byte_valid && !byte_stall;
    assign q_valid    = (count_reg != '0);
    assign q_word     = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the accepted word into its slot
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= byte_word;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (count_reg != '0))
        else $error("pop from empty queue");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push without count increase");

endmodule

@@ hw/rtl/apfp_back.sv @@
// Back end: parses queued bytes into fields and holds each result in an output register.
module apfp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  apfp_pkg::in_word_t q_word,
    output logic               q_pop,
    output logic               field_valid,
    input  logic               field_stall,
    output apfp_pkg::out_word_t field_word
);
    import apfp_pkg::*;

    logic [CODE_W-1:0]  phase_reg,   phase_next;
    logic [INDEX_W-1:0] index_reg,   index_next;
    logic [63:0]        acc_reg,     acc_next;
    logic [7:0]         io_id_reg,   io_id_next;
    logic [7:0]         left_reg,    left_next;
    logic               valid_reg;
    out_word_t          word_reg;

    logic [CODE_W-1:0]  cur_phase;
    logic [CODE_W-1:0]  follow;
    logic               emit;
    out_word_t          result;

    function automatic logic is_entry(input logic [CODE_W-1:0] code);
        return (code == F_IO1_ENTRY) || (code == F_IO2_ENTRY) ||
               (code == F_IO4_ENTRY) || (code == F_IO8_ENTRY);
    endfunction

    function automatic logic is_group_count(input logic [CODE_W-1:0] code);
        return (code == F_IO1_COUNT) || (code == F_IO2_COUNT) ||
               (code == F_IO4_COUNT) || (code == F_IO8_COUNT);
    endfunction

    // Take a word whenever the output slot is free or being emptied
    assign q_pop       = q_valid && (!valid_reg || !field_stall);
    assign field_valid = valid_reg;
    assign field_word  = word_reg;

    // Assemble the current field and pick the next one
    always_comb
    begin
        phase_next = phase_reg;
        index_next = index_reg;
        acc_next   = acc_reg;
        io_id_next = io_id_reg;
        left_next  = left_reg;
        follow     = '0;
        emit       = 1'b0;
        result     = '0;
        if (q_word.packet_start)
        begin
            phase_next = F_PREAMBLE;
            index_next = '0;
            acc_next   = '0;
            io_id_next = '0;
            left_next  = '0;
        end
        cur_phase = phase_next;
        if (cur_phase < PHASE_IDLE)
        begin
            if (is_entry(cur_phase) && (index_next == '0))
            begin
                io_id_next = q_word.data_byte;
            end
            else
            begin
                acc_next = {acc_next[55:0], q_word.data_byte};
            end
            index_next = index_next + 1'b1;
            if (index_next >= field_len(cur_phase))
            begin
                emit               = 1'b1;
                result.field_code  = cur_phase;
                result.io_id       = is_entry(cur_phase) ? io_id_next : 8'd0;
                result.field_value = acc_next;
                result.packet_end  = (cur_phase == F_CRC);
                follow = cur_phase + 1'b1;
                if (is_group_count(cur_phase))
                begin
                    left_next = acc_next[7:0];
                    if (acc_next[7:0] == 8'd0)
                    begin
                        follow = cur_phase + 5'd2;
                    end
                end
                else if (is_entry(cur_phase))
                begin
                    left_next = left_next - 1'b1;
                    if (left_next != 8'd0)
                    begin
                        follow = cur_phase;
                    end
                end
                phase_next = follow;
                index_next = '0;
                acc_next   = '0;
                if (!is_entry(follow))
                begin
                    io_id_next = '0;
                end
            end
        end
    end

    // Update parse state on each taken word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_IDLE;
            index_reg <= '0;
            acc_reg   <= '0;
            io_id_reg <= '0;
            left_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg <= phase_next;
                index_reg <= index_next;
                acc_reg   <= acc_next;
                io_id_reg <= io_id_next;
                left_reg  <= left_next;
            end
            if (q_pop && emit)
            begin
                valid_reg <= 1'b1;
            end
            else if (!field_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Load the output register with each finished field
    always_ff @(posedge clk)
    begin
        if (q_pop && emit)
        begin
            word_reg <= result;
        end
    end

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PHASE_IDLE)
        else $error("parse phase out of range");

    a_end_on_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && word_reg.packet_end) |-> (word_reg.field_code == F_CRC))
        else $error("packet end on a field other than crc");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        index_reg < 4'd9)
        else $error("byte index beyond longest field");

endmodule

@@ hw/rtl/avl_packet_field_parser.sv @@
// Top level of the AVL packet field parser: byte queue in front, field parser behind.
//
// Takes one raw packet byte per cycle and emits one word per completed field
// (code, IO id, big-endian value, end flag). A byte is taken in every cycle while
// the byte queue has room; the parser consumes one queued byte per cycle while its
// output register is free or being emptied, updating its field state as it takes
// each byte, so the sustained rate is one byte per cycle when the output does not
// stall. A field passes through a queue slot, then the parser's output register.
// A stalled output holds its word and lets the queue (QUEUE_DEPTH words) absorb
// further bytes before the byte side stalls. Bytes outside a packet are dropped.
module avl_packet_field_parser #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  apfp_pkg::in_word_t  byte_word,
    output logic                field_valid,
    input  logic                field_stall,
    output apfp_pkg::out_word_t field_word
);
    import apfp_pkg::*;

    logic     q_valid;
    logic     q_pop;
    in_word_t q_word;

    apfp_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_word  (byte_word),
        .q_valid    (q_valid),
        .q_word     (q_word),
        .q_pop      (q_pop)
    );

    apfp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_word      (q_word),
        .q_pop       (q_pop),
        .field_valid (field_valid),
        .field_stall (field_stall),
        .field_word  (field_word)
    );

endmodule
